// ===== hw/rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer-to-decimal converter
// Widths, ASCII codes, the pipeline stage payload and the shift-add-3 step.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_W        = 32;
  localparam int MAG_W          = 32;  // 2^31 still fits unsigned
  localparam int DIGIT_W        = 4;
  localparam int NUM_DIGITS     = 10;
  localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W         = 8;
  localparam int POS_W          = 4;
  localparam int BITS_PER_STAGE = 8;
  localparam int DABBLE_STAGES  = MAG_W / BITS_PER_STAGE;
  localparam int WORK_W         = BCD_W + MAG_W;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
  localparam logic [DIGIT_W-1:0] ADJUST     = 4'd3;

  typedef struct packed {
    logic               neg;
    logic [BCD_W-1:0]   bcd;
    logic [MAG_W-1:0]   bin;
  } itoa_stage_t;

  // Eight shift-add-3 steps: moves the top eight binary bits into the BCD field.
  function automatic itoa_stage_t dabble_step8(input itoa_stage_t s);
    itoa_stage_t       r;
    logic [WORK_W-1:0] w;
    r = s;
    w = {s.bcd, s.bin};
    for (int step = 0; step < BITS_PER_STAGE; step++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (w[MAG_W + DIGIT_W*d +: DIGIT_W] >= DIGIT_FIVE) begin
          w[MAG_W + DIGIT_W*d +: DIGIT_W] = w[MAG_W + DIGIT_W*d +: DIGIT_W] + ADJUST;
        end
      end
      w = {w[WORK_W-2:0], 1'b0};
    end
    r.bcd = w[WORK_W-1:MAG_W];
    r.bin = w[MAG_W-1:0];
    return r;
  endfunction

  // Index of the most significant nonzero digit, 0 when the value is zero.
  function automatic logic [POS_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
    logic [POS_W-1:0] idx;
    idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[DIGIT_W*d +: DIGIT_W] != '0) begin
        idx = POS_W'(d);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Pipelined binary-to-BCD conversion followed by a character serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_value/in_valid/in_stall: one signed 32-bit integer per
//   transfer. Output channel out_character/out_last/out_valid/out_stall: one
//   ASCII character per transfer, most significant first, '-' ahead of a
//   negative number, out_last high on the final digit. One number yields
//   1 to 11 characters.
//   Path: the first character is offered once the number has passed the
//   sign/magnitude stage, four shift-add-3 stages of eight bits and one
//   digit-count stage, then the serializer register.
//   Flow: the serializer emits one character per cycle while out_stall is
//   low and loads the next number in the cycle that its final character
//   transfers. The pipeline ahead of it holds up to six more numbers.
//   Reset (rst_n low, synchronous) empties the pipeline and the serializer.
//   When the receiver stalls, the output holds and the pipeline fills up
//   behind it; in_stall rises once every stage is occupied.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [itoa_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic        [itoa_pkg::CHAR_W-1:0]  out_character,
  output logic                                out_last,
  output logic                                out_valid,
  input  logic                                out_stall
);
  import itoa_pkg::*;

  // stage 0: sign and magnitude; stages 1..DABBLE_STAGES: BCD conversion
  itoa_stage_t      stg_r   [0:DABBLE_STAGES];
  logic             stg_v_r [0:DABBLE_STAGES];
  logic             stg_rdy [0:DABBLE_STAGES];

  // digit-count stage
  logic             cnt_v_r;
  logic             cnt_neg_r;
  logic [BCD_W-1:0] cnt_bcd_r;
  logic [POS_W-1:0] cnt_msd_r;
  logic             cnt_rdy;

  // serializer
  logic                                busy_r,   busy_nxt;
  logic                                negp_r,   negp_nxt;
  logic [POS_W-1:0]                    pos_r,    pos_nxt;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits_r, digits_nxt;
  logic                                ser_rdy;
  logic                                ser_load;
  logic                                ser_adv;

  logic [MAG_W-1:0] in_mag;

  // ready chain
  assign ser_rdy = !busy_r || (!out_stall && out_last);
  assign cnt_rdy = !cnt_v_r || ser_rdy;

  always_comb begin
    stg_rdy[DABBLE_STAGES] = !stg_v_r[DABBLE_STAGES] || cnt_rdy;
    for (int i = DABBLE_STAGES - 1; i >= 0; i--) begin
      stg_rdy[i] = !stg_v_r[i] || stg_rdy[i+1];
    end
  end

  assign in_stall = !stg_rdy[0];

  assign in_mag = in_value[VALUE_W-1] ? (~in_value + 1'b1) : in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r[0] <= 1'b0;
    end else if (stg_rdy[0]) begin
      stg_v_r[0] <= in_valid;
    end
    if (stg_rdy[0]) begin
      stg_r[0].neg <= in_value[VALUE_W-1];
      stg_r[0].bcd <= '0;
      stg_r[0].bin <= in_mag;
    end
  end

  for (genvar g = 1; g <= DABBLE_STAGES; g++) begin : g_dabble
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_v_r[g] <= 1'b0;
      end else if (stg_rdy[g]) begin
        stg_v_r[g] <= stg_v_r[g-1];
      end
      if (stg_rdy[g]) begin
        stg_r[g] <= dabble_step8(stg_r[g-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_v_r <= 1'b0;
    end else if (cnt_rdy) begin
      cnt_v_r <= stg_v_r[DABBLE_STAGES];
    end
    if (cnt_rdy) begin
      cnt_neg_r <= stg_r[DABBLE_STAGES].neg;
      cnt_bcd_r <= stg_r[DABBLE_STAGES].bcd;
      cnt_msd_r <= top_digit(stg_r[DABBLE_STAGES].bcd);
    end
  end

  // serializer: sign first, then digits from the top one down to the ones digit
  assign ser_load = cnt_v_r && ser_rdy;
  assign ser_adv  = busy_r && !out_stall;

  always_comb begin
    busy_nxt   = busy_r;
    negp_nxt   = negp_r;
    pos_nxt    = pos_r;
    digits_nxt = digits_r;
    if (ser_adv) begin
      if (out_last) begin
        busy_nxt = 1'b0;
      end else if (negp_r) begin
        negp_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r - 1'b1;
      end
    end
    if (ser_load) begin
      busy_nxt   = 1'b1;
      negp_nxt   = cnt_neg_r;
      pos_nxt    = cnt_msd_r;
      digits_nxt = cnt_bcd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    negp_r   <= negp_nxt;
    pos_r    <= pos_nxt;
    digits_r <= digits_nxt;
  end

  assign out_valid     = busy_r;
  assign out_last      = !negp_r && (pos_r == '0);
  assign out_character = negp_r ? CHAR_MINUS
                                : (CHAR_ZERO + CHAR_W'(digits_r[pos_r]));

  // every digit leaving the converter is a valid decimal digit
  logic bcd_ok;
  always_comb begin
    bcd_ok = 1'b1;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (stg_r[DABBLE_STAGES].bcd[DIGIT_W*d +: DIGIT_W] > DIGIT_NINE) begin
        bcd_ok = 1'b0;
      end
    end
  end

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r[DABBLE_STAGES] |-> bcd_ok)
    else $error("converter produced a non-decimal digit");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  (out_character >= CHAR_ZERO && out_character <= CHAR_NINE))
    else $error("output character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == CHAR_MINUS |-> !out_last)
    else $error("minus sign flagged as final character");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ser_load && !cnt_neg_r |=> out_character != CHAR_ZERO || out_last)
    else $error("leading zero emitted");

endmodule
